// ----- hw/rtl/bloom_filter_fnv_two_hash_top_assert.svh -----
// ----------------------------------------------------------------------------
// Bloom filter assertion macros
// Implication checks on the clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_FNV_TWO_HASH_TOP_ASSERT_SVH
`define BLOOM_FILTER_FNV_TWO_HASH_TOP_ASSERT_SVH

// same-cycle implication
`define BFF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bloom filter check failed");

// next-cycle implication
`define BFF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bloom filter check failed");

`endif

// ----- hw/rtl/bff_pkg.sv -----
// ----------------------------------------------------------------------------
// Bloom filter package
// Hash constants, opcodes, result kinds and the FNV-1a round.
// ----------------------------------------------------------------------------
package bff_pkg;

   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [63:0] SEED_MIX  = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] FNV_SEED2 = FNV_BASIS ^ SEED_MIX;

   localparam int unsigned CFG_W   = 11;
   localparam int unsigned WIDX_W  = 58;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_QUERY = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
      logic hit;
   } store_status_type;

   // multiplier 2^40 + 0x1b3
   function automatic logic [63:0] fnv_round(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x * 64'h1b3);
   endfunction

endpackage

// ----- hw/rtl/bff_mod.sv -----
// ----------------------------------------------------------------------------
// Bloom filter word index remainder
// Bit-serial restoring remainder of a 58-bit word index by the word count.
// ----------------------------------------------------------------------------
module bff_mod
   import bff_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [WIDX_W-1:0]    dividend,
   input  logic [CFG_W-1:0]     divisor,
   output logic                 done,
   output logic [CFG_W-1:0]     remainder
);

   localparam int unsigned CNT_W = $clog2(WIDX_W);

   logic                active_ff, active_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [WIDX_W-1:0]   dvd_ff, dvd_in;
   logic [CFG_W-1:0]    dsr_ff, dsr_in;
   logic [CFG_W-1:0]    rem_ff, rem_in;
   logic [CFG_W:0]      trial;

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      dvd_in    = dvd_ff;
      dsr_in    = dsr_ff;
      rem_in    = rem_ff;
      trial     = {rem_ff, dvd_ff[WIDX_W-1]};
      if (go) begin
         active_in = 1'b1;
         cnt_in    = '0;
         dvd_in    = dividend;
         dsr_in    = divisor;
         rem_in    = '0;
      end else if (active_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = CFG_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = CFG_W'(trial);
         end
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WIDX_W - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- hw/rtl/bff_store.sv -----
// ----------------------------------------------------------------------------
// Bloom filter bit store
// Word memory with read-modify-write probes and a clearing sweep.
// ----------------------------------------------------------------------------
module bff_store
   import bff_pkg::*;
#(
   parameter int unsigned MAX_WORDS = 1024
)
(
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  probe,
   input  logic                                  set,
   input  logic [(MAX_WORDS > 1 ? $clog2(MAX_WORDS) : 1)-1:0] addr,
   input  logic [63:0]                           mask,
   input  logic                                  clear,
   output store_status_type                      status
);

   localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_CLEAR = 2'd2;

   logic [63:0]   mem [MAX_WORDS];
   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] addr_ff;
   logic [63:0]   mask_ff;
   logic          set_ff;
   logic [63:0]   rd_data_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [63:0]   wr_data;
   logic          last_word;

   assign last_word = (cnt_ff == AW'(MAX_WORDS - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      wr_en    = 1'b0;
      wr_addr  = addr_ff;
      wr_data  = rd_data_ff | mask_ff;
      status   = '{busy: 1'b0, done: 1'b0, hit: |(rd_data_ff & mask_ff)};
      unique case (state_ff)
         ST_IDLE: begin
            if (clear) begin
               state_in = ST_CLEAR;
               cnt_in   = '0;
            end else if (probe) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            wr_en       = set_ff;
            status.done = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_CLEAR: begin
            status.busy = 1'b1;
            wr_en       = 1'b1;
            wr_addr     = cnt_ff;
            wr_data     = '0;
            cnt_in      = cnt_ff + 1'b1;
            if (last_word) begin
               status.done = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      if (state_ff == ST_IDLE && probe) begin
         addr_ff <= addr;
         mask_ff <= mask;
         set_ff  <= set;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (state_ff == ST_IDLE && probe) begin
         rd_data_ff <= mem[addr];
      end
   end

endmodule

// ----- hw/rtl/bloom_filter_fnv_two_hash_top.sv -----
// ----------------------------------------------------------------------------
// Bloom filter with FNV-1a double hashing
// Takes one key byte per command; add, query or clear a bit store.
// ----------------------------------------------------------------------------
// A command transfers when start is high and busy is low. After the last key
// byte come second-hash rounds over the eight bytes of the first hash, then
// per probe a bit-serial remainder of the 58-bit word index and a
// read-modify-write of the store. Clear writes one word per cycle; after
// reset the same sweep runs with busy high. Each result is on rsp_* for one
// cycle with rsp_strobe high and cannot be held off.
module bloom_filter_fnv_two_hash_top
   import bff_pkg::*;
#(
   parameter int unsigned MAX_WORDS  = 1024,
   parameter int unsigned HASH_COUNT = 2
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_opcode,
   input  logic [7:0]        req_key_byte,
   input  logic              req_last_byte,
   output logic              rsp_strobe,
   output logic [1:0]        rsp_result_kind,
   output logic              rsp_maybe_present,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CFG_W-1:0]  csr_data
);

   localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int unsigned IW = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_H2    = 3'd1;
   localparam logic [2:0] S_MGO   = 3'd2;
   localparam logic [2:0] S_MWAIT = 3'd3;
   localparam logic [2:0] S_PWAIT = 3'd4;
   localparam logic [2:0] S_CLR   = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [CFG_W-1:0]  words_ff;
   logic [CFG_W-1:0]  words_eff;
   logic [63:0]       hash_ff, hash_in;
   logic [63:0]       h1sh_ff, h1sh_in;
   logic [63:0]       h2_ff, h2_in;
   logic [63:0]       pos_ff, pos_in;
   logic [2:0]        bcnt_ff, bcnt_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [1:0]        op_ff, op_in;
   logic              pres_ff, pres_in;
   logic              strobe_ff, strobe_in;
   logic [1:0]        kind_ff, kind_in;
   logic              mp_ff, mp_in;
   logic [63:0]       round_out;
   logic              accept;

   logic              mod_go;
   logic              mod_done;
   logic [CFG_W-1:0]  mod_rem;
   logic              st_probe;
   logic              st_clear;
   store_status_type  st_status;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE) || st_status.busy;
   assign csr_ready = 1'b1;

   always_comb begin
      if (words_ff == '0) begin
         words_eff = CFG_W'(1);
      end else if (words_ff > MAX_WORDS) begin
         words_eff = CFG_W'(MAX_WORDS);
      end else begin
         words_eff = words_ff;
      end
   end

   assign round_out = fnv_round(hash_ff, req_key_byte);

   always_comb begin
      state_in  = state_ff;
      hash_in   = hash_ff;
      h1sh_in   = h1sh_ff;
      h2_in     = h2_ff;
      pos_in    = pos_ff;
      bcnt_in   = bcnt_ff;
      idx_in    = idx_ff;
      op_in     = op_ff;
      pres_in   = pres_ff;
      strobe_in = 1'b0;
      kind_in   = kind_ff;
      mp_in     = mp_ff;
      mod_go    = 1'b0;
      st_probe  = 1'b0;
      st_clear  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority if (req_opcode == OP_CLEAR) begin
                  hash_in  = FNV_BASIS;
                  st_clear = 1'b1;
                  state_in = S_CLR;
               end else if (req_opcode == OP_NONE) begin
                  state_in = S_IDLE;
               end else if (!req_last_byte) begin
                  hash_in = round_out;
               end else begin
                  hash_in  = FNV_BASIS;
                  h1sh_in  = round_out;
                  pos_in   = round_out;
                  h2_in    = FNV_SEED2;
                  bcnt_in  = '0;
                  idx_in   = '0;
                  op_in    = req_opcode;
                  pres_in  = 1'b1;
                  state_in = S_H2;
               end
            end
         end
         S_H2: begin
            h2_in   = fnv_round(h2_ff, h1sh_ff[7:0]);
            h1sh_in = h1sh_ff >> 8;
            bcnt_in = bcnt_ff + 1'b1;
            if (bcnt_ff == 3'd7) begin
               state_in = S_MGO;
            end
         end
         S_MGO: begin
            mod_go   = 1'b1;
            state_in = S_MWAIT;
         end
         S_MWAIT: begin
            if (mod_done) begin
               st_probe = 1'b1;
               state_in = S_PWAIT;
            end
         end
         S_PWAIT: begin
            if (st_status.done) begin
               if (!st_status.hit) begin
                  pres_in = 1'b0;
               end
               if (idx_ff == IW'(HASH_COUNT - 1)) begin
                  strobe_in = 1'b1;
                  kind_in   = op_ff;
                  mp_in     = (op_ff == OP_QUERY) && pres_in;
                  state_in  = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  pos_in   = pos_ff + h2_ff;
                  state_in = S_MGO;
               end
            end
         end
         S_CLR: begin
            if (st_status.done) begin
               strobe_in = 1'b1;
               kind_in   = KIND_CLEAR;
               mp_in     = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         hash_ff   <= FNV_BASIS;
         words_ff  <= CFG_W'(1024);
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         hash_ff   <= hash_in;
         strobe_ff <= strobe_in;
         if (csr_valid && csr_ready) begin
            words_ff <= csr_data;
         end
      end
      h1sh_ff <= h1sh_in;
      h2_ff   <= h2_in;
      pos_ff  <= pos_in;
      bcnt_ff <= bcnt_in;
      idx_ff  <= idx_in;
      op_ff   <= op_in;
      pres_ff <= pres_in;
      kind_ff <= kind_in;
      mp_ff   <= mp_in;
   end

   bff_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .go        (mod_go),
      .dividend  (pos_ff[63:6]),
      .divisor   (words_eff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   bff_store #(
      .MAX_WORDS (MAX_WORDS)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .probe  (st_probe),
      .set    (op_ff == OP_ADD),
      .addr   (AW'(mod_rem)),
      .mask   (64'd1 << pos_ff[5:0]),
      .clear  (st_clear),
      .status (st_status)
   );

   assign rsp_strobe        = strobe_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_maybe_present = mp_ff;

`include "bloom_filter_fnv_two_hash_top_assert.svh"

   `BFF_ASSERT_NEXT(a_clear_holds_busy, start && !busy && req_opcode == OP_CLEAR, busy)
   `BFF_ASSERT_NEXT(a_single_strobe, rsp_strobe, !rsp_strobe)
   `BFF_ASSERT_SAME(a_present_only_query, rsp_strobe && rsp_result_kind != KIND_QUERY, !rsp_maybe_present)

endmodule
